>>> rtl/u8sd_pkg.sv
// Shared types, byte-class constants and helpers of the UTF-8 stream decoder.
package u8sd_pkg;

  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam int CP_W = 21;

  typedef logic [CP_W-1:0] code_point_t;

  // one accepted input byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } item_t;

  // up to three results caused by one input byte
  typedef struct packed {
    logic [1:0]            count;
    code_point_t [2:0]     cp;
    logic                  end_of_buffer;
  } bundle_t;

  // sequence tracker state, visible for checking
  typedef struct packed {
    logic [1:0] held_count;
    logic [1:0] needed_count;
  } dec_status_t;

  // number of followers a lead byte needs, zero when not a multi-byte lead
  function automatic logic [1:0] follow_len(input logic [7:0] c);
    logic [1:0] k;
    k = 2'd0;
    if ((c & ASCII_MASK) == 8'h00) begin
      k = 2'd0;
    end else if ((c & LEAD2_MASK) == LEAD2_CODE) begin
      k = 2'd1;
    end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
      k = 2'd2;
    end else if ((c & LEAD4_MASK) == LEAD4_CODE) begin
      k = 2'd3;
    end
    return k;
  endfunction

  function automatic code_point_t raw_cp(input logic [7:0] c);
    return {13'd0, c};
  endfunction

endpackage

>>> rtl/u8sd_skid.sv
// Input skid stage: registered ready, two item slots.
module u8sd_skid
  import u8sd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  input  logic  item_take,
  output item_t item
);

  logic  main_valid;
  logic  skid_valid;
  item_t main_item;
  item_t skid_item;
  logic  in_xfer;

  assign in_ready   = !skid_valid;
  assign in_xfer    = in_valid && in_ready;
  assign item_valid = main_valid;
  assign item       = main_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || item_take) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || item_take) begin
      if (skid_valid) begin
        main_item <= skid_item;
      end else if (in_xfer) begin
        main_item <= in_item;
      end
    end else if (in_xfer) begin
      skid_item <= in_item;
    end
  end

endmodule

>>> rtl/u8sd_decode.sv
// Sequence tracker and single-pass decode of one byte into a result bundle.
module u8sd_decode
  import u8sd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  item_t       item,
  output bundle_t     bundle,
  output dec_status_t status
);

  logic [7:0] held_bytes [3];
  logic [1:0] held_count;
  logic [1:0] needed_count;
  logic [1:0] held_count_next;
  logic [1:0] needed_count_next;
  logic       hold_byte;
  logic [1:0] k;
  logic [7:0] c;

  assign c = item.in_byte;
  assign k = follow_len(c);

  always_comb begin
    bundle            = '0;
    bundle.end_of_buffer = item.end_of_buffer;
    held_count_next   = held_count;
    needed_count_next = needed_count;
    hold_byte         = 1'b0;
    if (held_count == 2'd0) begin
      if (k != 2'd0 && !item.end_of_buffer) begin
        hold_byte         = 1'b1;
        held_count_next   = 2'd1;
        needed_count_next = k;
      end else begin
        bundle.count = 2'd1;
        bundle.cp[0] = raw_cp(c);
      end
    end else if (held_count == needed_count) begin
      // sequence complete
      bundle.count = 2'd1;
      case (needed_count)
        2'd1:    bundle.cp[0] = {10'd0, held_bytes[0][4:0], c[5:0]};
        2'd2:    bundle.cp[0] = {5'd0, held_bytes[0][3:0], held_bytes[1][5:0], c[5:0]};
        default: bundle.cp[0] = {held_bytes[0][2:0], held_bytes[1][5:0],
                                 held_bytes[2][5:0], c[5:0]};
      endcase
      held_count_next   = 2'd0;
      needed_count_next = 2'd0;
    end else if (!item.end_of_buffer) begin
      hold_byte       = 1'b1;
      held_count_next = held_count + 2'd1;
    end else begin
      // buffer ends early: lead raw, then the bytes behind it raw, or a two-byte pair decoded
      bundle.cp[0] = raw_cp(held_bytes[0]);
      if (held_count == 2'd1) begin
        bundle.count = 2'd2;
        bundle.cp[1] = raw_cp(c);
      end else if (follow_len(held_bytes[1]) == 2'd1) begin
        bundle.count = 2'd2;
        bundle.cp[1] = {10'd0, held_bytes[1][4:0], c[5:0]};
      end else begin
        bundle.count = 2'd3;
        bundle.cp[1] = raw_cp(held_bytes[1]);
        bundle.cp[2] = raw_cp(c);
      end
      held_count_next   = 2'd0;
      needed_count_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      needed_count <= 2'd0;
    end else if (take) begin
      held_count   <= held_count_next;
      needed_count <= needed_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hold_byte) begin
      held_bytes[held_count] <= c;
    end
  end

  assign status.held_count   = held_count;
  assign status.needed_count = needed_count;

endmodule

>>> rtl/u8sd_emit.sv
// Result register: holds one bundle and sends its results one per transfer.
module u8sd_emit
  import u8sd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  bundle_t     bundle_in,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output code_point_t code_point,
  output logic        run_last,
  output logic        buffer_done
);

  bundle_t    bundle;
  logic       bundle_valid;
  logic [1:0] idx;
  logic       last_sel;
  logic       out_xfer;

  assign last_sel    = (idx == bundle.count - 2'd1);
  assign out_xfer    = bundle_valid && out_ready;
  assign can_load    = !bundle_valid || (out_xfer && last_sel);
  assign out_valid   = bundle_valid;
  assign run_last    = last_sel;
  assign buffer_done = last_sel && bundle.end_of_buffer;

  always_comb begin
    case (idx)
      2'd0:    code_point = bundle.cp[0];
      2'd1:    code_point = bundle.cp[1];
      2'd2:    code_point = bundle.cp[2];
      default: code_point = bundle.cp[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bundle_valid <= 1'b0;
      idx          <= 2'd0;
    end else if (load) begin
      bundle_valid <= 1'b1;
      idx          <= 2'd0;
    end else if (out_xfer) begin
      if (last_sel) begin
        bundle_valid <= 1'b0;
        idx          <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bundle <= bundle_in;
    end
  end

endmodule

>>> rtl/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder: skid input, decode, result register.
//
// Input channel (in_valid/in_ready): one byte of a text buffer per transfer,
// end_of_buffer marks the buffer's final byte. Output channel
// (out_valid/out_ready): one code point per transfer, run_last on the final
// result of an input byte, buffer_done on the final result of the buffer.
// A byte that only extends a pending multi-byte sequence gives no result.
// When the buffer ends inside a sequence, one byte gives up to three results.
//
// A transferred byte waits in the skid main slot, is decoded from there and
// loads the result register, which offers its first result. One byte per
// cycle while out_ready holds and each byte gives at most one result; a byte with
// several results holds the result register until all are sent; decode waits on it.
// in_ready comes from a register (two-slot skid stage), so a stalled receiver
// first fills the skid slot and then drops in_ready; no byte is lost.
// Reset clears the pending sequence, the skid slots and the result register;
// held bytes of a pending sequence are not cleared.
module utf8_stream_decoder_unit
  import u8sd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] code_point,
  output logic        run_last,
  output logic        buffer_done
);

  item_t       in_item;
  item_t       item;
  logic        item_valid;
  logic        item_take;
  bundle_t     bundle;
  dec_status_t status;
  logic        can_load;
  logic        load;

  assign in_item.in_byte       = in_byte;
  assign in_item.end_of_buffer = end_of_buffer;

  // advance the head byte when its results fit, or when it only extends a sequence
  assign item_take = item_valid && (can_load || bundle.count == 2'd0);
  assign load      = item_take && (bundle.count != 2'd0);

  u8sd_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  u8sd_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .take   (item_take),
    .item   (item),
    .bundle (bundle),
    .status (status)
  );

  u8sd_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .bundle_in   (bundle),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .run_last    (run_last),
    .buffer_done (buffer_done)
  );

  // a pending sequence never holds more bytes than its lead asks for
  a_held_bounded: assert property (@(posedge clk) disable iff (rst)
    status.held_count <= status.needed_count)
    else $error("held byte count exceeds needed count");

  // buffer end leaves no pending sequence behind
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    item_take && item.end_of_buffer |=> status.held_count == 2'd0)
    else $error("pending sequence survives end of buffer");

  // a non-final result is always followed by another result
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid)
    else $error("result run broken before its final result");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && buffer_done |-> run_last)
    else $error("buffer_done on a non-final result");

endmodule
